// File: src/feistel_id_scrambler_32_defines.svh
// assertion macros for the scrambler
`ifndef FEISTEL_ID_SCRAMBLER_32_DEFINES_SVH
`define FEISTEL_ID_SCRAMBLER_32_DEFINES_SVH
// plain implication check
`define FIS_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("check failed");
// next-cycle implication check
`define FIS_ASSERT_NXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("check failed");
`endif

// File: src/fis_pkg.sv
package fis_pkg;
   localparam int unsigned NumPasses = 2;
   localparam int unsigned NumRounds = 4;
   localparam int unsigned NumSteps = 4;
   localparam logic [31:0] ModA = 32'h0000ffff;
   localparam logic [31:0] ModB = 32'h00010000;
   localparam logic [31:0] WalkLimit = 32'hffff0000;
   localparam int unsigned DefaultStages = NumPasses * (NumRounds * NumSteps + 2);

   typedef enum logic {
      CMD_SCRAMBLE = 1'b0,
      CMD_UNSCRAMBLE = 1'b1
   } cmd_type;

   typedef struct packed {
      logic        inv;
      logic        active;
      logic [31:0] high;
      logic [15:0] l;
      logic [15:0] r;
      logic [31:0] acc;
      logic [31:0] word;
   } work_type;

   function automatic logic [31:0] round_seed(input logic [1:0] j);
      logic [31:0] s;
      case (j)
         2'd0: s = 32'hb76d5eed;
         2'd1: s = 32'hee281300;
         2'd2: s = 32'h85bcae01;
         default: s = 32'h4b387af7;
      endcase
      return s;
   endfunction

   // a mod 0xffff for a < 2*0xffff
   function automatic logic [15:0] red_a(input logic [16:0] a);
      logic [16:0] d;
      d = (a >= 17'h0ffff) ? a - 17'h0ffff : a;
      return d[15:0];
   endfunction

   // x mod 0xffff via folding
   function automatic logic [15:0] mod_a32(input logic [31:0] x);
      logic [16:0] s;
      s = {1'b0, x[31:16]} + {1'b0, x[15:0]};
      s = {16'd0, s[16]} + {1'b0, s[15:0]};
      return red_a(s);
   endfunction
endpackage

// File: src/fis_if.sv
interface fis_if #(parameter int unsigned Width = 1);
   logic             valid;
   logic             ready;
   logic [Width-1:0] payload;
   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

// File: src/fis_cell.sv
// one stage of the chain: split, one hash step of a round, or join
module fis_cell #(
   parameter int unsigned Kind = 0
) (
   input  logic              clock,
   input  logic              en,
   input  fis_pkg::work_type d_in,
   output fis_pkg::work_type d_out
);
   import fis_pkg::*;
   // kind: 0 split, then four hash steps per round, last one join
   localparam int unsigned JoinKind = NumRounds * NumSteps + 1;
   localparam int unsigned RoundIdx = (Kind == 0) ? 0 : (Kind - 1) / NumSteps;
   localparam int unsigned StepIdx = (Kind == 0) ? 0 : (Kind - 1) % NumSteps;
   localparam logic [1:0] FwdRound = 2'(RoundIdx % NumRounds);
   localparam logic [1:0] InvRound = 2'(NumRounds - 1 - (RoundIdx % NumRounds));
   work_type    w_ff, w_in;
   logic [31:0] k, h;
   logic [15:0] key, f16, t;
   logic [16:0] s;
   logic [1:0]  rj;
   logic [31:0] q, rm, m;
   logic [47:0] prod;

   always_comb begin
      w_in = d_in;
      k = '0; h = '0; key = '0; f16 = '0; t = '0; s = '0;
      q = '0; rm = '0; m = '0; prod = '0;
      rj = d_in.inv ? InvRound : FwdRound;
      if (Kind == 0) begin
         m = d_in.word;
         prod = 48'(m) * 48'h10001;
         q = {16'd0, prod[47:32]};
         rm = m - 32'(q * 32'h0000ffff);
         if (rm >= ModA) begin
            rm = rm - ModA;
            q = q + 32'd1;
         end
         if (!d_in.inv) begin
            w_in.l = rm[15:0];
            w_in.r = q[15:0];
         end else if (q == ModA) begin
            w_in.l = rm[15:0];
            w_in.r = 16'hffff;
         end else begin
            w_in.l = q[15:0];
            w_in.r = rm[15:0];
         end
      end else if (Kind < JoinKind) begin
         key = d_in.inv ? d_in.l : d_in.r;
         if (StepIdx == 0) begin
            // key scaling
            w_in.acc = {16'd0, key} * 32'hcc9e2d51;
         end else if (StepIdx == 1) begin
            // rotate, second key multiply, seed mix
            k = {d_in.acc[16:0], d_in.acc[31:17]};
            k = k * 32'h1b873593;
            h = round_seed(rj) ^ k ^ 32'd2;
            w_in.acc = h ^ (h >> 16);
         end else if (StepIdx == 2) begin
            h = d_in.acc * 32'h85ebca6b;
            w_in.acc = h ^ (h >> 13);
         end else begin
            // finish the hash and apply the round
            h = d_in.acc * 32'hc2b2ae35;
            h = h ^ (h >> 16);
            if (!rj[0]) f16 = mod_a32(h);
            else f16 = h[15:0];
            if (!d_in.inv) begin
               s = {1'b0, f16} + {1'b0, d_in.l};
               t = rj[0] ? s[15:0] : red_a(s);
               w_in.l = d_in.r;
               w_in.r = t;
            end else begin
               if (rj[0]) t = d_in.r - f16;
               else begin
                  s = {1'b0, d_in.r} + 17'h0ffff - {1'b0, f16};
                  t = red_a(s);
               end
               w_in.r = d_in.l;
               w_in.l = t;
            end
         end
      end else begin
         if (!d_in.inv && d_in.r == 16'hffff)
            m = 32'hfffe0001 + {16'd0, d_in.l};
         else if (!d_in.inv)
            m = 32'({d_in.l, 16'd0} - {16'd0, d_in.l}) + {16'd0, d_in.r};
         else
            m = 32'({d_in.r, 16'd0} - {16'd0, d_in.r}) + {16'd0, d_in.l};
         if (d_in.active) w_in.word = m;
         w_in.active = d_in.active && (m >= WalkLimit);
      end
   end

   always_ff @(posedge clock) begin
      if (en) w_ff <= w_in;
   end
   assign d_out = w_ff;
endmodule

// File: src/feistel_id_scrambler_32.sv
// channel | dir | payload
// req     | in  | cmd (1), value (64)
// rsp     | out | result (64)
// 36 cells: per pass a split, four rounds of four hash steps each, and a join
// a word passes through every cell register before it leaves, one word per cycle when rsp is ready
// at most one multiply per hash step keeps each step short; the second pass always runs
// reset clears the valid bits only
// a stalled rsp freezes the whole chain; the output register holds the word
`include "feistel_id_scrambler_32_defines.svh"
module feistel_id_scrambler_32 (
   input logic clock,
   input logic reset,
   fis_if.sink   req,
   fis_if.source rsp
);
   import fis_pkg::*;
   localparam int unsigned Stages = DefaultStages;
   localparam int unsigned PassLen = NumRounds * NumSteps + 2;

   work_type chain [0:Stages];
   work_type head_w;
   logic [Stages-1:0] vld_ff;
   logic en;
   logic [31:0] lo;

   // chain advances when the last slot is empty or being taken
   assign en = !vld_ff[Stages-1] || rsp.ready;
   assign req.ready = en;

   // the first pass is active only if the low half is at least 0x10000
   always_comb begin
      head_w.inv = req.payload[64];
      head_w.high = req.payload[63:32];
      lo = req.payload[31:0];
      head_w.active = lo >= ModB;
      head_w.word = lo - ModB;
      head_w.l = '0;
      head_w.r = '0;
      head_w.acc = '0;
   end
   assign chain[0] = head_w;

   genvar g;
   generate
      for (g = 0; g < Stages; g++) begin : g_cell
         fis_cell #(.Kind(g % PassLen)) u_cell (
            .clock(clock), .en(en),
            .d_in(chain[g]), .d_out(chain[g+1])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (en) vld_ff <= {vld_ff[Stages-2:0], req.valid};
   end

   logic [31:0] res_lo;
   // the last join rewrote the word only when the first pass landed at or above the walk limit
   assign res_lo = chain[Stages].word + ModB;
   assign rsp.valid = vld_ff[Stages-1];
   assign rsp.payload = {chain[Stages].high, res_lo};

   `FIS_ASSERT_NXT(a_hold, clock, reset, rsp.valid && !rsp.ready, rsp.valid)
   `FIS_ASSERT_IMP(a_ready, clock, reset, !rsp.valid, req.ready)
endmodule

// File: tb/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import fis_pkg::*;

   // one request word: direction plus identifier
   typedef struct {
      cmd_type     cmd;
      logic [63:0] value;
   } id_item;

   logic clock;
   logic reset;

   fis_if #(.Width(65)) req_ch ();
   fis_if #(.Width(64)) rsp_ch ();

   feistel_id_scrambler_32 DUT (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source)
   );

   // pending words, expected identifiers and bookkeeping
   id_item      pending_ids[$];
   logic [63:0] expected_ids[$];
   int          mismatch_count = 0;
   int          words_sent = 0;
   int          words_seen = 0;
   int          walk_hits = 0;
   int          small_hits = 0;
   bit          stimulus_done = 0;
   bit          calm_phase = 0;
   int          req_gap = 0;
   int          rsp_stall = 0;
   logic        req_taken = 0;

   // clock, period 10 ns
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // murmur3 x86_32 over the two low bytes of key
   function automatic logic [31:0] mix_hash(input logic [31:0] seed, input logic [31:0] key);
      logic [31:0] h;
      logic [31:0] k;
      k = key & 32'h0000ffff;
      k = k * 32'hcc9e2d51;
      k = {k[16:0], k[31:17]};
      k = k * 32'h1b873593;
      h = seed ^ k;
      h = h ^ 32'd2;
      h = h ^ (h >> 16);
      h = h * 32'h85ebca6b;
      h = h ^ (h >> 13);
      h = h * 32'hc2b2ae35;
      h = h ^ (h >> 16);
      return h;
   endfunction

   function automatic logic [31:0] feistel_fwd(input logic [31:0] m);
      logic [31:0] l;
      logic [31:0] r;
      logic [31:0] f;
      logic [31:0] md;
      logic [32:0] sum;
      l = m % ModA;
      r = m / ModA;
      for (int j = 0; j < 4; j++) begin
         f = mix_hash(round_seed(j[1:0]), r);
         md = (j % 2 == 0) ? ModA : ModB;
         sum = ({1'b0, f} + {1'b0, l}) % {1'b0, md};
         l = r;
         r = sum[31:0];
      end
      return (r == ModA) ? r * ModA + l : l * ModA + r;
   endfunction

   function automatic logic [31:0] feistel_inv(input logic [31:0] m);
      logic [31:0] q;
      logic [31:0] l;
      logic [31:0] r;
      logic [31:0] f;
      logic [31:0] md;
      logic [32:0] sum;
      q = m / ModA;
      if (q == ModA) begin
         l = m % ModA;
         r = ModA;
      end else begin
         l = q;
         r = m % ModA;
      end
      for (int j = 3; j >= 0; j--) begin
         md = (j % 2 == 0) ? ModA : ModB;
         f = mix_hash(round_seed(j[1:0]), l) % md;
         sum = ({1'b0, r} + {1'b0, md} - {1'b0, f}) % {1'b0, md};
         r = l;
         l = sum[31:0];
      end
      return ModA * r + l;
   endfunction

   // expected identifier; counts small values and cycle walks on the way
   function automatic logic [63:0] scramble_id(input id_item it);
      logic [31:0] v;
      logic [31:0] c;
      v = it.value[31:0];
      if (v < ModB) begin
         small_hits++;
         return it.value;
      end
      c = (it.cmd == CMD_SCRAMBLE) ? feistel_fwd(v - ModB) : feistel_inv(v - ModB);
      if (c >= WalkLimit) begin
         walk_hits++;
         c = (it.cmd == CMD_SCRAMBLE) ? feistel_fwd(c) : feistel_inv(c);
      end
      return {it.value[63:32], ModB + c};
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
      mismatch_count++;
   endtask

   // gap length: mostly none or short, now and then long
   function automatic int pick_gap();
      int p;
      if (calm_phase) return 0;
      p = $urandom_range(99);
      if (p < 55) return 0;
      if (p < 90) return $urandom_range(3, 1);
      return $urandom_range(30, 5);
   endfunction

   task automatic add_id(input cmd_type cmd, input logic [63:0] value);
      id_item it;
      it.cmd = cmd;
      it.value = value;
      pending_ids = {pending_ids, it};
   endtask

   // request side: changes at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.payload <= '0;
      end else if (!req_ch.valid || req_taken) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_ch.valid <= 1'b0;
         end else if (pending_ids.size() > 0) begin
            id_item it;
            it = pending_ids.pop_front();
            req_ch.payload <= {it.cmd, it.value};
            req_ch.valid <= 1'b1;
            req_gap <= pick_gap();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // result side backpressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
         if ($urandom_range(3) == 0) rsp_stall <= pick_gap();
      end
   end

   // sample both handshakes at the rising edge
   always @(posedge clock) begin
      req_taken <= !reset && req_ch.valid && req_ch.ready;
      if (!reset && req_ch.valid && req_ch.ready) begin
         id_item it;
         it.cmd = cmd_type'(req_ch.payload[64]);
         it.value = req_ch.payload[63:0];
         expected_ids = {expected_ids, scramble_id(it)};
         words_sent++;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         words_seen++;
         if (expected_ids.size() == 0) begin
            report_mismatch("unexpected result", rsp_ch.payload, '0);
         end else begin
            logic [63:0] want;
            want = expected_ids.pop_front();
            if (rsp_ch.payload !== want) report_mismatch("result", rsp_ch.payload, want);
         end
      end
   end

   // stimulus and end of run
   initial begin
      logic [63:0] v;
      logic [31:0] lo;
      int p;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;

      // directed: field extremes, both directions, small values, inverse split,
      // values near the walk limit
      for (int d = 0; d < 2; d++) begin
         add_id(cmd_type'(d), 64'h0);
         add_id(cmd_type'(d), 64'h0000_0000_0000_ffff);
         add_id(cmd_type'(d), 64'hffff_ffff_0000_1234);
         add_id(cmd_type'(d), 64'h0000_0000_0001_0000);
         add_id(cmd_type'(d), 64'h0000_0000_ffff_ffff);
         add_id(cmd_type'(d), 64'hffff_ffff_ffff_ffff);
         add_id(cmd_type'(d), 64'h5a5a_a5a5_ffff_0001);
         add_id(cmd_type'(d), 64'h0000_0000_ffff_0000);
         add_id(cmd_type'(d), 64'h8000_0000_fffe_ffff);
         add_id(cmd_type'(d), 64'h0123_4567_89ab_cdef);
         add_id(cmd_type'(d), 64'h0000_0001_0001_0001);
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // random: mostly permuted range, some small, some near the top
      for (int i = 0; i < 1150; i++) begin
         if (i % 200 == 100) calm_phase = 1;
         if (i % 200 == 150) calm_phase = 0;
         p = $urandom_range(99);
         if (p < 10) lo = $urandom_range(32'hffff);
         else if (p < 25) lo = $urandom_range(32'hffffffff, 32'hfffd0000);
         else lo = $urandom_range(32'hffffffff, 32'h10000);
         v = {$urandom(), lo};
         add_id(cmd_type'($urandom_range(1)), v);
         while (pending_ids.size() > 16) @(posedge clock);
      end

      while (pending_ids.size() > 0 || req_ch.valid) @(posedge clock);
      stimulus_done = 1;
      while (expected_ids.size() > 0) @(posedge clock);
      repeat (3 * DefaultStages + 10) @(posedge clock);

      $display("covered %0d identifiers both ways, %0d results checked", words_sent, words_seen);
      $display("%0d left unchanged as small, %0d needed a second pass", small_hits, walk_hits);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("timeout, %0d results still expected", expected_ids.size());
      $display("Regression FAIL");
      $finish;
   end
endmodule
